// ===== design/lhni_pkg.sv =====
`timescale 1ns / 1ps

package lhni_pkg;

  localparam int ID_W    = 16;
  localparam int COORD_W = 32;
  localparam int SIZE_W  = COORD_W - 1;
  localparam int CFG_W   = 1;

  typedef logic [CFG_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_QUERY_POSITION = 1'd0;
  localparam cfg_idx_t CFG_REVERSED       = 1'd1;

  typedef struct packed {
    logic        [ID_W-1:0]    frame_id;
    logic signed [COORD_W-1:0] span_start;
    logic        [SIZE_W-1:0]  span_size;
    logic                      last_item;
  } in_t;

  typedef struct packed {
    logic [ID_W-1:0] found_id;
    logic            before_first;
    logic            after_last;
  } out_t;

  typedef struct packed {
    logic                      search_done;
    logic                      have_first;
    logic        [ID_W-1:0]    first_id;
    logic                      have_before;
    logic        [ID_W-1:0]    before_id;
    logic signed [COORD_W:0]   before_end;
    logic                      have_after;
    logic        [ID_W-1:0]    after_id;
    logic signed [COORD_W-1:0] after_start;
  } cand_t;

endpackage

// ===== design/lhni_scan.sv =====
`timescale 1ns / 1ps

module lhni_scan (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic signed [lhni_pkg::COORD_W-1:0] query_position,
  input  logic                                item_fire,
  input  lhni_pkg::in_t                       item,
  output lhni_pkg::cand_t                     cand_nxt
);

  localparam int W = lhni_pkg::COORD_W;

  lhni_pkg::cand_t        cand_r;
  logic signed [W:0]      pos_ext;
  logic signed [W:0]      span_end;
  logic                   start_le;
  logic                   start_lt;
  logic                   end_gt;

  assign pos_ext  = {query_position[W-1], query_position};
  assign span_end = {item.span_start[W-1], item.span_start} + {2'b00, item.span_size};
  assign start_le = item.span_start <= query_position;
  assign start_lt = item.span_start < query_position;
  assign end_gt   = span_end > pos_ext;

  always_comb begin
    cand_nxt = cand_r;
    if (!cand_r.search_done) begin
      if (!cand_r.have_first) begin
        cand_nxt.have_first = 1'b1;
        cand_nxt.first_id   = item.frame_id;
      end
      if (item.span_size != '0) begin
        priority if (start_le && end_gt) begin
          cand_nxt.search_done = 1'b1;
          cand_nxt.have_before = 1'b1;
          cand_nxt.have_after  = 1'b1;
          cand_nxt.before_id   = item.frame_id;
          cand_nxt.after_id    = item.frame_id;
        end else if (start_lt) begin
          if (!cand_r.have_before || span_end > cand_r.before_end) begin
            cand_nxt.have_before = 1'b1;
            cand_nxt.before_id   = item.frame_id;
            cand_nxt.before_end  = span_end;
          end
        end else begin
          if (!cand_r.have_after || item.span_start < cand_r.after_start) begin
            cand_nxt.have_after  = 1'b1;
            cand_nxt.after_id    = item.frame_id;
            cand_nxt.after_start = item.span_start;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r <= '0;
    end else if (item_fire) begin
      if (item.last_item) begin
        cand_r <= '0;
      end else begin
        cand_r <= cand_nxt;
      end
    end
  end

`ifndef SYNTH
  a_done_has_both: assert property (@(posedge clk) disable iff (!rst_n)
    cand_r.search_done |-> cand_r.have_before && cand_r.have_after)
    else $error("search done without containing interval recorded");

  a_run_clears: assert property (@(posedge clk) disable iff (!rst_n)
    item_fire && item.last_item |=>
      !cand_r.search_done && !cand_r.have_first && !cand_r.have_before && !cand_r.have_after)
    else $error("run state not cleared after final transaction");
`endif

endmodule

// ===== design/line_hit_nearest_interval_core.sv =====
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in_      input      in_valid / in_stall  lhni_pkg::in_t
// out_     output     out_valid/out_stall  lhni_pkg::out_t
// cfg_     input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One interval per cycle unless stalled: input register, then scan compares with run state.
// A final interval lands in a snapshot register; the midpoint pick feeds the output register.
// A final interval passes the input, snapshot and output registers before result valid.
// Synchronous active-low reset clears run state and valids; query_position and reversed to 0.
// in_stall rises only when a final interval waits for a full snapshot and output stage.

module line_hit_nearest_interval_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  lhni_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output lhni_pkg::out_t                   out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  lhni_pkg::cfg_idx_t               cfg_index,
  input  logic [lhni_pkg::COORD_W-1:0]     cfg_data
);

  localparam int W = lhni_pkg::COORD_W;

  logic signed [W-1:0]  pos_r;
  logic                 rev_r;

  lhni_pkg::in_t        a_r;
  logic                 a_valid_r;
  logic                 a_fire;
  logic                 in_take;

  lhni_pkg::cand_t      cand_nxt;
  lhni_pkg::cand_t      snap_r;
  logic                 snap_valid_r;
  logic                 b_ready;
  logic                 c_ld;

  lhni_pkg::out_t       out_r;
  lhni_pkg::out_t       out_nxt;
  logic                 out_valid_r;

  logic signed [W+1:0]  pos_x;
  logic signed [W+1:0]  bend_x;
  logic signed [W+1:0]  astart_x;
  logic signed [W+1:0]  delta;
  logic signed [W+1:0]  mid;
  logic                 no_before;
  logic                 no_after;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      rev_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lhni_pkg::CFG_QUERY_POSITION: pos_r <= cfg_data;
        lhni_pkg::CFG_REVERSED:       rev_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign b_ready  = !snap_valid_r || c_ld;
  assign a_fire   = a_valid_r && (!a_r.last_item || b_ready);
  assign in_stall = a_valid_r && !a_fire;
  assign in_take  = in_valid && !in_stall;
  assign c_ld     = snap_valid_r && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_take) begin
      a_valid_r <= 1'b1;
    end else if (a_fire) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_r <= in_data;
    end
  end

  lhni_scan u_scan (
    .clk            (clk),
    .rst_n          (rst_n),
    .query_position (pos_r),
    .item_fire      (a_fire),
    .item           (a_r),
    .cand_nxt       (cand_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_valid_r <= 1'b0;
    end else if (a_fire && a_r.last_item) begin
      snap_valid_r <= 1'b1;
    end else if (c_ld) begin
      snap_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_fire && a_r.last_item) begin
      snap_r <= cand_nxt;
    end
  end

  assign pos_x    = {{2{pos_r[W-1]}}, pos_r};
  assign bend_x   = {snap_r.before_end[W], snap_r.before_end};
  assign astart_x = {{2{snap_r.after_start[W-1]}}, snap_r.after_start};
  assign delta    = astart_x - bend_x;
  assign mid      = bend_x + (delta >>> 1);

  always_comb begin
    out_nxt   = '0;
    no_before = 1'b0;
    no_after  = 1'b0;
    priority if (snap_r.search_done) begin
      out_nxt.found_id = snap_r.before_id;
    end else if (!snap_r.have_before && !snap_r.have_after) begin
      out_nxt.found_id = snap_r.first_id;
    end else begin
      no_before = !snap_r.have_before;
      no_after  = !snap_r.have_after;
      priority if (!snap_r.have_before) begin
        out_nxt.found_id = snap_r.after_id;
      end else if (!snap_r.have_after) begin
        out_nxt.found_id = snap_r.before_id;
      end else if (pos_x < mid) begin
        out_nxt.found_id = snap_r.before_id;
      end else begin
        out_nxt.found_id = snap_r.after_id;
      end
    end
    out_nxt.before_first = rev_r ? no_after : no_before;
    out_nxt.after_last   = rev_r ? no_before : no_after;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (c_ld) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTH
  a_snap_holds: assert property (@(posedge clk) disable iff (!rst_n)
    snap_valid_r && !c_ld |=> snap_valid_r && $stable(snap_r))
    else $error("pending snapshot lost or changed");

  a_hit_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
    c_ld && snap_r.search_done |=> !out_r.before_first && !out_r.after_last)
    else $error("containing interval reported with edge flags");
`endif

endmodule
